// ===== hdl/keypad_poll_backlight_battery_unit_defines.svh =====
// assertion macros shared by the keypad poll unit
`ifndef KEYPAD_POLL_BACKLIGHT_BATTERY_UNIT_DEFINES_SVH
`define KEYPAD_POLL_BACKLIGHT_BATTERY_UNIT_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define KPBB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kpbb same-cycle check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define KPBB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kpbb next-cycle check failed");

`endif

// ===== hdl/kpbb_pkg.sv =====
// shared types, constants and the key encoder for the keypad poll unit
`timescale 1ns / 1ps

package kpbb_pkg;

    localparam int unsigned DIV_W        = 10;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned LEVEL_W      = 10;
    localparam int unsigned KEY_W        = 3;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned IN_DATA_W    = 48;
    localparam int unsigned OUT_DATA_W   = 8;

    localparam logic [DIV_W-1:0] CHECK_DIVIDE = 10'd255;
    localparam logic [DIV_W-1:0] OUTER_RESET  = 10'h2FF;
    localparam logic [DIV_W-1:0] INNER_RESET  = 10'h0FF;

    localparam logic [TIME_W-1:0]  TIMEOUT_RESET  = 32'd10000;
    localparam logic [LEVEL_W-1:0] WARN_RESET     = 10'd600;
    localparam logic [LEVEL_W-1:0] CRITICAL_RESET = 10'd550;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd2;

    // key codes
    localparam logic [KEY_W-1:0] KEY_NONE  = 3'd0;
    localparam logic [KEY_W-1:0] KEY_UP    = 3'd1;
    localparam logic [KEY_W-1:0] KEY_SEL   = 3'd2;
    localparam logic [KEY_W-1:0] KEY_LEFT  = 3'd3;
    localparam logic [KEY_W-1:0] KEY_RIGHT = 3'd4;
    localparam logic [KEY_W-1:0] KEY_DN    = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0]  backlight_timeout_ms;
        logic [LEVEL_W-1:0] warn_level;
        logic [LEVEL_W-1:0] critical_level;
    } t_cfg;

    typedef struct packed {
        logic               up_n;
        logic               select_n;
        logic               left_n;
        logic               right_n;
        logic               down_n;
        logic [TIME_W-1:0]  now_ms;
        logic [LEVEL_W-1:0] battery_sample;
    } t_poll;

    typedef struct packed {
        logic [KEY_W-1:0] key_event;
        logic             backlight_on;
        logic             battery_critical;
        logic             show_low_banner;
        logic             show_normal_banner;
    } t_result;

    // priority encode of active-low buttons, up first
    function automatic logic [KEY_W-1:0] encode_key(input t_poll p);
        logic [KEY_W-1:0] k;
        if (!p.up_n) begin
            k = KEY_UP;
        end else if (!p.select_n) begin
            k = KEY_SEL;
        end else if (!p.left_n) begin
            k = KEY_LEFT;
        end else if (!p.right_n) begin
            k = KEY_RIGHT;
        end else if (!p.down_n) begin
            k = KEY_DN;
        end else begin
            k = KEY_NONE;
        end
        return k;
    endfunction

endpackage

// ===== hdl/kpbb_cfg_regs.sv =====
// configuration register file: timeout, warning and critical levels
`timescale 1ns / 1ps

module kpbb_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [kpbb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kpbb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output kpbb_pkg::t_cfg                     o_cfg
);

    kpbb_pkg::t_cfg r_cfg;
    kpbb_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                kpbb_pkg::REG_TIMEOUT: begin
                    n_cfg.backlight_timeout_ms = i_cfg_data;
                end
                kpbb_pkg::REG_WARN: begin
                    n_cfg.warn_level = i_cfg_data[kpbb_pkg::LEVEL_W-1:0];
                end
                kpbb_pkg::REG_CRITICAL: begin
                    n_cfg.critical_level = i_cfg_data[kpbb_pkg::LEVEL_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.backlight_timeout_ms <= kpbb_pkg::TIMEOUT_RESET;
            r_cfg.warn_level           <= kpbb_pkg::WARN_RESET;
            r_cfg.critical_level       <= kpbb_pkg::CRITICAL_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/kpbb_poll_core.sv =====
// poll state and per-poll logic: key change, backlight timer, battery prescaler
`timescale 1ns / 1ps

module kpbb_poll_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  kpbb_pkg::t_poll     i_poll,
    input  kpbb_pkg::t_cfg      i_cfg,
    output kpbb_pkg::t_result   o_result
);

    logic [kpbb_pkg::KEY_W-1:0]  r_last_key,   n_last_key;
    logic [kpbb_pkg::TIME_W-1:0] r_press_time, n_press_time;
    logic                        r_backlight,  n_backlight;
    logic [kpbb_pkg::DIV_W-1:0]  r_poll_div,   n_poll_div;
    logic [kpbb_pkg::DIV_W-1:0]  r_check_div,  n_check_div;
    logic                        r_low_batt,   n_low_batt;

    logic [kpbb_pkg::KEY_W-1:0]  key;
    logic [kpbb_pkg::TIME_W-1:0] elapsed;
    logic [kpbb_pkg::DIV_W-1:0]  poll_inc;
    logic [kpbb_pkg::DIV_W-1:0]  check_inc;
    logic                        check_now;

    always_comb begin
        key        = kpbb_pkg::encode_key(i_poll);
        elapsed    = i_poll.now_ms - r_press_time;
        poll_inc   = r_poll_div + 1'b1;
        check_inc  = r_check_div + 1'b1;
        check_now  = 1'b0;

        n_last_key   = key;
        n_press_time = r_press_time;
        n_poll_div   = poll_inc;
        n_check_div  = r_check_div;
        n_low_batt   = r_low_batt;

        o_result = '0;

        n_backlight = (elapsed >= i_cfg.backlight_timeout_ms) ? 1'b0 : r_backlight;
        if (key != kpbb_pkg::KEY_NONE) begin
            n_press_time = i_poll.now_ms;
            n_backlight  = 1'b1;
        end

        // two-level prescaler, inner stage advances only on outer carry
        if (poll_inc >= kpbb_pkg::CHECK_DIVIDE) begin
            n_poll_div  = '0;
            n_check_div = check_inc;
            if (check_inc >= kpbb_pkg::CHECK_DIVIDE) begin
                n_check_div = '0;
                check_now   = 1'b1;
            end
        end

        // critical wins over warning whatever the level order
        if (check_now) begin
            if (i_poll.battery_sample <= i_cfg.critical_level) begin
                o_result.battery_critical = 1'b1;
            end else if (i_poll.battery_sample <= i_cfg.warn_level) begin
                if (!r_low_batt) begin
                    o_result.show_low_banner = 1'b1;
                    n_low_batt               = 1'b1;
                end
            end else if (r_low_batt) begin
                o_result.show_normal_banner = 1'b1;
                n_low_batt                  = 1'b0;
            end
        end

        o_result.key_event    = (key != r_last_key) ? key : kpbb_pkg::KEY_NONE;
        o_result.backlight_on = n_backlight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_key   <= kpbb_pkg::KEY_NONE;
            r_press_time <= '0;
            r_backlight  <= 1'b0;
            r_poll_div   <= kpbb_pkg::OUTER_RESET;
            r_check_div  <= kpbb_pkg::INNER_RESET;
            r_low_batt   <= 1'b0;
        end else if (i_fire) begin
            r_last_key   <= n_last_key;
            r_press_time <= n_press_time;
            r_backlight  <= n_backlight;
            r_poll_div   <= n_poll_div;
            r_check_div  <= n_check_div;
            r_low_batt   <= n_low_batt;
        end
    end

endmodule

// ===== hdl/keypad_poll_backlight_battery_unit.sv =====
// top level: input register, poll core, result register, configuration port
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+---------------------------------
//  s (poll)  | in        | i_s_tvalid / o_s_tready    | i_s_tdata, 48 bits
//  m (event) | out       | o_m_tvalid / i_m_tready    | o_m_tdata, 8 bits
//  cfg       | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one poll per cycle sustained while the output is not stalled; a poll's result is on
// o_m_tdata in the cycle after the one in which the poll leaves the input register
// the poll state is one register set updated in the cycle a poll moves to the result register
// i_rst_n is synchronous: it empties both registers and reloads state and configuration
// a stall on the output holds the result, then the input register, then o_s_tready drops
// configuration writes are always taken
`timescale 1ns / 1ps
`include "keypad_poll_backlight_battery_unit_defines.svh"

module keypad_poll_backlight_battery_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [0] up_n, [1] select_n, [2] left_n, [3] right_n, [4] down_n,
    // [36:5] now_ms, [46:37] battery_sample, [47] zero
    input  logic [kpbb_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [2:0] key_event, [3] backlight_on, [4] battery_critical,
    // [5] show_low_banner, [6] show_normal_banner, [7] zero
    output logic [kpbb_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kpbb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kpbb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                                   r_in_valid;
    logic [kpbb_pkg::IN_DATA_W-1:0]         r_in_data;
    logic                                   r_out_valid;
    logic [kpbb_pkg::OUT_DATA_W-1:0]        r_out_data;

    logic              advance;
    logic              in_take;
    kpbb_pkg::t_poll   poll;
    kpbb_pkg::t_cfg    cfg;
    kpbb_pkg::t_result result;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_comb begin
        poll.up_n           = r_in_data[0];
        poll.select_n       = r_in_data[1];
        poll.left_n         = r_in_data[2];
        poll.right_n        = r_in_data[3];
        poll.down_n         = r_in_data[4];
        poll.now_ms         = r_in_data[36:5];
        poll.battery_sample = r_in_data[46:37];
    end

    kpbb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kpbb_poll_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_poll   (poll),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {1'b0, result.show_normal_banner, result.show_low_banner,
                           result.battery_critical, result.backlight_on, result.key_event};
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

    // a poll leaving the input register always lands in the result register
    `KPBB_ASSERT_NEXT(a_advance_fills_out, advance, r_out_valid)
    // a held poll is not dropped while the output is stalled
    `KPBB_ASSERT_NEXT(a_in_held, r_in_valid && !advance, r_in_valid)
    // a reported key implies the backlight came on in that poll
    `KPBB_ASSERT_SAME(a_key_lights, r_out_valid && (r_out_data[2:0] != kpbb_pkg::KEY_NONE),
                      r_out_data[3])
    // at most one battery outcome per check
    `KPBB_ASSERT_SAME(a_batt_onehot, r_out_valid, $onehot0(r_out_data[6:4]))

endmodule

// ===== sim/kpbb_poll_monitor.sv =====
// poll monitor: predicts the keypad unit's result stream and compares every output transfer
`timescale 1ns / 1ps

module kpbb_poll_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [kpbb_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [kpbb_pkg::OUT_DATA_W-1:0]     i_m_tdata,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [kpbb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kpbb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic [31:0]                         o_failures,
    output logic [31:0]                         o_outstanding
);
    import kpbb_pkg::*;

    // own copy of the unit's state and settings
    t_cfg               settings;
    logic [KEY_W-1:0]   held_key;
    logic [TIME_W-1:0]  press_stamp;
    logic               lamp_on;
    logic [DIV_W-1:0]   poll_count;
    logic [DIV_W-1:0]   check_count;
    logic               batt_low;

    t_result            pending_events[$];
    int unsigned        failures = 0;
    int unsigned        outstanding = 0;

    assign o_failures    = failures;
    assign o_outstanding = outstanding;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        failures++;
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic t_poll unpack_poll(input logic [IN_DATA_W-1:0] d);
        t_poll p;
        p.up_n           = d[0];
        p.select_n       = d[1];
        p.left_n         = d[2];
        p.right_n        = d[3];
        p.down_n         = d[4];
        p.now_ms         = d[36:5];
        p.battery_sample = d[46:37];
        return p;
    endfunction

    // advances the poll state by one poll and returns the result it should produce
    function automatic t_result next_poll_event(input t_poll p);
        t_result            r;
        logic [KEY_W-1:0]   key;
        logic [4:0]         pressed;
        logic [TIME_W-1:0]  elapsed;
        r = '0;
        r.key_event = KEY_NONE;
        poll_count = poll_count + 1'b1;

        elapsed = p.now_ms - press_stamp;
        if (elapsed >= settings.backlight_timeout_ms) begin
            lamp_on = 1'b0;
        end

        // active high, up in bit 0 wins
        pressed = ~{p.down_n, p.right_n, p.left_n, p.select_n, p.up_n};
        casez (pressed)
            5'b????1: key = KEY_UP;
            5'b???10: key = KEY_SEL;
            5'b??100: key = KEY_LEFT;
            5'b?1000: key = KEY_RIGHT;
            5'b10000: key = KEY_DN;
            default:  key = KEY_NONE;
        endcase

        if (key != KEY_NONE) begin
            press_stamp = p.now_ms;
            lamp_on     = 1'b1;
        end

        if (poll_count >= CHECK_DIVIDE) begin
            poll_count  = '0;
            check_count = check_count + 1'b1;
            if (check_count >= CHECK_DIVIDE) begin
                check_count = '0;
                // critical wins even when its level sits above the warning level
                if (p.battery_sample <= settings.critical_level) begin
                    r.battery_critical = 1'b1;
                end else if (p.battery_sample <= settings.warn_level) begin
                    if (!batt_low) begin
                        r.show_low_banner = 1'b1;
                        batt_low          = 1'b1;
                    end
                end else if (batt_low) begin
                    r.show_normal_banner = 1'b1;
                    batt_low             = 1'b0;
                end
            end
        end

        if (key != held_key) begin
            held_key    = key;
            r.key_event = key;
        end
        r.backlight_on = lamp_on;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            settings.backlight_timeout_ms = TIMEOUT_RESET;
            settings.warn_level           = WARN_RESET;
            settings.critical_level       = CRITICAL_RESET;
            held_key    = KEY_NONE;
            press_stamp = '0;
            lamp_on     = 1'b0;
            poll_count  = OUTER_RESET;
            check_count = INNER_RESET;
            batt_low    = 1'b0;
            pending_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TIMEOUT:  settings.backlight_timeout_ms = i_cfg_data;
                    REG_WARN:     settings.warn_level = i_cfg_data[LEVEL_W-1:0];
                    REG_CRITICAL: settings.critical_level = i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end

            // retire before predicting: a result never belongs to a poll of the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.key_event          = i_m_tdata[2:0];
                got.backlight_on       = i_m_tdata[3];
                got.battery_critical   = i_m_tdata[4];
                got.show_low_banner    = i_m_tdata[5];
                got.show_normal_banner = i_m_tdata[6];
                if (pending_events.size() == 0) begin
                    report_mismatch("result with no poll waiting", 32'(i_m_tdata), '0);
                end else begin
                    want = pending_events.pop_front();
                    if (got.key_event !== want.key_event)
                        report_mismatch("key_event", 32'(got.key_event),
                                        32'(want.key_event));
                    if (got.backlight_on !== want.backlight_on)
                        report_mismatch("backlight_on", 32'(got.backlight_on),
                                        32'(want.backlight_on));
                    if (got.battery_critical !== want.battery_critical)
                        report_mismatch("battery_critical", 32'(got.battery_critical),
                                        32'(want.battery_critical));
                    if (got.show_low_banner !== want.show_low_banner)
                        report_mismatch("show_low_banner", 32'(got.show_low_banner),
                                        32'(want.show_low_banner));
                    if (got.show_normal_banner !== want.show_normal_banner)
                        report_mismatch("show_normal_banner", 32'(got.show_normal_banner),
                                        32'(want.show_normal_banner));
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                pending_events.push_back(next_poll_event(unpack_poll(i_s_tdata)));
            end
        end
        outstanding = pending_events.size();
    end

endmodule

// ===== sim/keypad_poll_backlight_battery_unit_test.sv =====
// testbench top: poll and configuration stimulus, output stalls and the final verdict
`timescale 1ns / 1ps

module keypad_poll_backlight_battery_unit_test;
    import kpbb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // index the unit ignores

    // active-low button patterns, up in bit 0 through down in bit 4
    localparam logic [4:0] NO_KEYS      = 5'b11111;
    localparam logic [4:0] ALL_KEYS     = 5'b00000;
    localparam logic [4:0] PRESS_UP     = 5'b11110;
    localparam logic [4:0] PRESS_SELECT = 5'b11101;
    localparam logic [4:0] PRESS_LEFT   = 5'b11011;
    localparam logic [4:0] PRESS_RIGHT  = 5'b10111;
    localparam logic [4:0] PRESS_DOWN   = 5'b01111;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [IN_DATA_W-1:0]       i_s_tdata;
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [OUT_DATA_W-1:0]      o_m_tdata;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    logic [31:0]                failures;
    logic [31:0]                outstanding;

    int unsigned                send_idle;
    int unsigned                recv_idle;
    int unsigned                hold_left;
    int unsigned                step_max;
    logic [4:0]                 held_buttons;
    logic [TIME_W-1:0]          clock_ms;

    keypad_poll_backlight_battery_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    kpbb_poll_monitor event_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    // output side stalls at random
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic send_poll(input logic [4:0] btn_n, input logic [TIME_W-1:0] now,
                             input logic [LEVEL_W-1:0] batt);
        while ($urandom_range(0, 99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, batt, now, btn_n};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // holds the sender until every predicted result has been taken
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // buttons are held for a few polls so repeats and releases both show up
    task automatic send_random_poll();
        if (hold_left == 0) begin
            hold_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0, 1:    held_buttons = NO_KEYS;
                2:       held_buttons = ~(5'b00001 << $urandom_range(0, 4));
                default: held_buttons = 5'($urandom());
            endcase
        end
        hold_left--;
        if ($urandom_range(0, 49) == 0) begin
            clock_ms = $urandom();
        end else begin
            clock_ms = clock_ms + $urandom_range(0, step_max);
        end
        send_poll(held_buttons, clock_ms, 10'($urandom_range(0, 1023)));
    endtask

    task automatic shuffle_config();
        logic [TIME_W-1:0] limit_ms;
        wait_idle();
        case ($urandom_range(0, 3))
            0:       limit_ms = '0;
            1:       limit_ms = $urandom_range(1, 60);
            2:       limit_ms = '1;
            default: limit_ms = $urandom();
        endcase
        write_reg(REG_TIMEOUT, limit_ms);
        write_reg(REG_WARN, $urandom());
        write_reg(REG_CRITICAL, $urandom());
        write_reg(REG_SPARE, $urandom());
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_m_tready   = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_TIMEOUT;
        i_cfg_data   = '0;
        send_idle    = 22;
        recv_idle    = 59;
        hold_left    = 0;
        step_max     = 40;
        held_buttons = NO_KEYS;
        clock_ms     = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first poll is a battery check under the reset levels: enters low
        send_poll(NO_KEYS, 32'd0, 10'd580);
        send_poll(PRESS_UP, 32'd100, 10'd0);
        send_poll(PRESS_UP, 32'd120, 10'd1023);
        send_poll(PRESS_SELECT, 32'd130, 10'd341);
        send_poll(PRESS_LEFT, 32'd140, 10'd682);
        send_poll(PRESS_RIGHT, 32'd150, 10'd0);
        send_poll(PRESS_DOWN, 32'd200, 10'd1023);
        // release, lamp on one ms short of the timeout, then off at it
        send_poll(NO_KEYS, 32'd10199, 10'd0);
        send_poll(NO_KEYS, 32'd10200, 10'd0);
        send_poll(ALL_KEYS, 32'hFFFF_FFF0, 10'd0);
        send_poll(5'b01101, 32'hFFFF_FFF8, 10'd0);
        send_poll(NO_KEYS, 32'd5, 10'd0);

        wait_idle();
        write_reg(REG_TIMEOUT, 32'd0);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_poll(PRESS_RIGHT, 32'd7, 10'd0);
        send_poll(NO_KEYS, 32'd7, 10'd0);

        wait_idle();
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        send_poll(PRESS_LEFT, 32'd1, 10'd0);
        send_poll(NO_KEYS, 32'd0, 10'd0);
        send_poll(PRESS_LEFT, 32'd0, 10'd0);
        send_poll(NO_KEYS, 32'hFFFF_FFFE, 10'd0);

        for (int round = 0; round < 6; round++) begin
            if (round == 2) begin
                send_idle = 59;
                recv_idle = 22;
            end else if (round == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            shuffle_config();
            for (int n = 0; n < 255; n++) begin
                if ($urandom_range(0, 199) == 0) wait_idle();
                send_random_poll();
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
